FILE: rtl/rcg_pkg.sv
// Package with the widths, codes and record types of the report claim generator.
`timescale 1ns / 1ps

package rcg_pkg;

   localparam int OFFSET_BITS = 48;
   localparam int UPPER_BITS  = OFFSET_BITS + 1;

   localparam int REQ_FIELD_W = 2 * OFFSET_BITS;
   localparam int REQ_DATA_W  = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = 2 * OFFSET_BITS + 2 * UPPER_BITS;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = UPPER_BITS;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LOWER_LIMIT = 2'd0,
      REG_UPPER_BOUND = 2'd1,
      REG_AUTO_LOWER  = 2'd2,
      REG_AUTO_UPPER  = 2'd3
   } rcg_reg_type;

   typedef enum logic [1:0] {
      KIND_CLAIM     = 2'd0,
      KIND_CLOSE_OK  = 2'd1,
      KIND_CLOSE_BAD = 2'd2
   } rcg_kind_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] lower_limit;
      logic [UPPER_BITS-1:0]  upper_bound;
      logic                   auto_lower;
      logic                   auto_upper;
   } rcg_cfg_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] frag_begin;
      logic [OFFSET_BITS-1:0] frag_end;
      logic                   final_fragment;
   } rcg_frag_type;

   typedef struct packed {
      rcg_kind_type           record_kind;
      logic [OFFSET_BITS-1:0] claim_offset;
      logic [UPPER_BITS-1:0]  claim_length;
      logic [OFFSET_BITS-1:0] report_lower;
      logic [UPPER_BITS-1:0]  report_upper;
      logic                   last_of_report;
   } rcg_record_type;

   typedef struct packed {
      logic           claim_valid;
      rcg_record_type claim;
      logic           close_valid;
      rcg_record_type close;
   } rcg_result_type;

endpackage

FILE: rtl/report_claim_generator_unit.sv
// Top level of the report claim generator.
`timescale 1ns / 1ps

// Usage:
//   req_* carries fragments (begin/end offsets in tdata, tlast marks the final
//   fragment of a report). rsp_* carries records: reception claims (tuser =
//   claim) and, after the final fragment, one closing record with tlast high
//   and tuser giving valid or invalid bounds.
//   csr_* writes the bounds and the auto-lower / auto-upper modes; write only
//   while no request is in flight.
// Path: an accepted request passes the input register, then the result register,
//   before its first record reaches rsp.
// Throughput: one request per cycle while rsp_tready stays high and each gives
//   at most one record; a final fragment that gives both a claim and a closing
//   record holds the input while both sit in the two-slot result register.
// Reset: synchronous; clears pipeline valids and report state, bounds to 0,
//   both auto modes on.
// Stall: while rsp_tready is low the record holds; one more request still
//   enters the input register, then req_tready drops.

module report_claim_generator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rcg_pkg::REQ_DATA_W-1:0]  req_tdata,  // frag_begin, frag_end
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // claim_offset, claim_length, report_lower, report_upper, zero pad
   output logic [rcg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                      rsp_tuser,  // record_kind
   output logic                            rsp_tlast,
   input  logic                            csr_wr_en,
   input  logic [rcg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rcg_pkg::*;

   rcg_cfg_type    cfg;
   rcg_frag_type   frag;
   rcg_result_type result;
   rcg_record_type out_rec;
   logic           frag_valid, can_load, advance;

   assign advance = frag_valid && can_load;

   rcg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rcg_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .frag_valid (frag_valid),
      .frag       (frag)
   );

   rcg_claim_calc u_calc (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .frag    (frag),
      .cfg     (cfg),
      .result  (result)
   );

   rcg_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .can_load  (can_load),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   assign rsp_tdata = RSP_DATA_W'({out_rec.report_upper, out_rec.report_lower,
                                   out_rec.claim_length, out_rec.claim_offset});
   assign rsp_tuser = out_rec.record_kind;
   assign rsp_tlast = out_rec.last_of_report;

endmodule

FILE: rtl/rcg_csr.sv
// Configuration registers of the report claim generator.
`timescale 1ns / 1ps

module rcg_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [rcg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output rcg_pkg::rcg_cfg_type            cfg
);
   import rcg_pkg::*;

   rcg_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (rcg_reg_type'(csr_index))
            REG_LOWER_LIMIT: cfg_in.lower_limit = csr_wdata[OFFSET_BITS-1:0];
            REG_UPPER_BOUND: cfg_in.upper_bound = csr_wdata[UPPER_BITS-1:0];
            REG_AUTO_LOWER:  cfg_in.auto_lower  = csr_wdata[0];
            REG_AUTO_UPPER:  cfg_in.auto_upper  = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_limit <= '0;
         cfg_ff.upper_bound <= '0;
         cfg_ff.auto_lower  <= 1'b1;
         cfg_ff.auto_upper  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/rcg_in_reg.sv
// Input register holding one accepted fragment request.
`timescale 1ns / 1ps

module rcg_in_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rcg_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   input  logic                           advance,
   output logic                           frag_valid,
   output rcg_pkg::rcg_frag_type          frag
);
   import rcg_pkg::*;

   logic         valid_ff, valid_in;
   rcg_frag_type frag_ff;
   logic         take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         frag_ff.frag_begin     <= req_tdata[OFFSET_BITS-1:0];
         frag_ff.frag_end       <= req_tdata[2*OFFSET_BITS-1:OFFSET_BITS];
         frag_ff.final_fragment <= req_tlast;
      end
   end

   assign frag_valid = valid_ff;
   assign frag       = frag_ff;

endmodule

FILE: rtl/rcg_claim_calc.sv
// Report state and the clipping logic that turns one fragment into claim and closing records.
`timescale 1ns / 1ps

module rcg_claim_calc (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  rcg_pkg::rcg_frag_type frag,
   input  rcg_pkg::rcg_cfg_type  cfg,
   output rcg_pkg::rcg_result_type result
);
   import rcg_pkg::*;

   logic                   first_seen_ff, first_seen_in;
   logic                   scope_ended_ff, scope_ended_in;
   logic [OFFSET_BITS-1:0] active_lower_ff, active_lower_in;
   logic [UPPER_BITS-1:0]  hep_ff, hep_in;

   logic                   first;
   logic [UPPER_BITS-1:0]  ep1, hep_prev, hep_new, up, lo_x, b_x, len_raw, room;
   logic [OFFSET_BITS-1:0] lo, b;
   logic                   scope_prev, invalid, scope_hit, claim_ok;

   always_comb begin
      first    = !first_seen_ff;
      ep1      = {1'b0, frag.frag_end} + UPPER_BITS'(1);
      lo       = first ? (cfg.auto_lower ? frag.frag_begin : cfg.lower_limit)
                       : active_lower_ff;
      hep_prev = first ? '0 : hep_ff;
      hep_new  = (ep1 > hep_prev) ? ep1 : hep_prev;
      up       = cfg.auto_upper ? hep_new : cfg.upper_bound;
      lo_x     = {1'b0, lo};
      invalid  = !(lo_x < up);
      scope_prev = first ? 1'b0 : scope_ended_ff;

      b        = (frag.frag_begin > lo) ? frag.frag_begin : lo;
      b_x      = {1'b0, b};
      len_raw  = ep1 - b_x;
      room     = up - b_x;

      // clipped begin at or past an explicit upper bound closes the scope
      scope_hit = !scope_prev && (ep1 > lo_x) && !cfg.auto_upper && (b_x >= up);
      claim_ok  = !scope_prev && (ep1 > lo_x) && !scope_hit && (ep1 > b_x) && (b_x < up);

      result.claim_valid          = claim_ok;
      result.claim.record_kind    = KIND_CLAIM;
      result.claim.claim_offset   = b - lo;
      result.claim.claim_length   = (len_raw > room) ? room : len_raw;
      result.claim.report_lower   = lo;
      result.claim.report_upper   = up;
      result.claim.last_of_report = 1'b0;

      result.close_valid          = frag.final_fragment;
      result.close.record_kind    = invalid ? KIND_CLOSE_BAD : KIND_CLOSE_OK;
      result.close.claim_offset   = '0;
      result.close.claim_length   = '0;
      result.close.report_lower   = lo;
      result.close.report_upper   = up;
      result.close.last_of_report = 1'b1;

      first_seen_in   = first_seen_ff;
      scope_ended_in  = scope_ended_ff;
      active_lower_in = active_lower_ff;
      hep_in          = hep_ff;
      if (advance) begin
         active_lower_in = lo;
         if (frag.final_fragment) begin
            first_seen_in  = 1'b0;
            scope_ended_in = 1'b0;
            hep_in         = '0;
         end else begin
            first_seen_in  = 1'b1;
            scope_ended_in = scope_prev || scope_hit;
            hep_in         = hep_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_seen_ff   <= 1'b0;
         scope_ended_ff  <= 1'b0;
         active_lower_ff <= '0;
         hep_ff          <= '0;
      end else begin
         first_seen_ff   <= first_seen_in;
         scope_ended_ff  <= scope_ended_in;
         active_lower_ff <= active_lower_in;
         hep_ff          <= hep_in;
      end
   end

endmodule

FILE: rtl/rcg_out_buf.sv
// Two-slot result register: claim slot drains before the closing slot.
`timescale 1ns / 1ps

module rcg_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  rcg_pkg::rcg_result_type result,
   output logic                    can_load,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rcg_pkg::rcg_record_type out_rec
);
   import rcg_pkg::*;

   logic           v0_ff, v0_in, v1_ff, v1_in;
   rcg_record_type r0_ff, r1_ff;
   logic           fire;

   assign out_valid = v0_ff || v1_ff;
   assign out_rec   = v0_ff ? r0_ff : r1_ff;
   assign fire      = out_valid && out_ready;
   // empty now, or one record left that leaves this cycle
   assign can_load  = (!v0_ff && !v1_ff) || (fire && (v0_ff != v1_ff));

   always_comb begin
      v0_in = v0_ff;
      v1_in = v1_ff;
      if (fire) begin
         if (v0_ff) begin
            v0_in = 1'b0;
         end else begin
            v1_in = 1'b0;
         end
      end
      if (load) begin
         v0_in = result.claim_valid;
         v1_in = result.close_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         r0_ff <= result.claim;
         r1_ff <= result.close;
      end
   end

endmodule

FILE: rtl/rcg_checker.sv
// Port-level checks of the report claim generator and their bind.
`timescale 1ns / 1ps

module rcg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [rcg_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rcg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [1:0]                      rsp_tuser,
   input logic                            rsp_tlast,
   input logic                            csr_wr_en,
   input logic [rcg_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [rcg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rcg_pkg::*;

   localparam int LEN_LO = OFFSET_BITS;
   localparam int LEN_HI = OFFSET_BITS + UPPER_BITS - 1;

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled record holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled record changed");

   // tlast marks exactly the closing records
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_CLAIM)))
      else $error("tlast does not match record kind");

   // claims carry a nonzero length, closing records carry none
   a_claim_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_CLAIM |-> rsp_tdata[LEN_HI:LEN_LO] != '0)
      else $error("claim with zero length");

   a_close_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[LEN_HI:0] == '0)
      else $error("closing record with offset or length");

endmodule

bind report_claim_generator_unit rcg_checker u_rcg_checker (.*);

FILE: dv/rcg_record_checker.sv
// Checker for the report claim generator: predicts records per request and compares them.
`timescale 1ns / 1ps

module rcg_record_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [rcg_pkg::REQ_DATA_W-1:0]  req_tdata,  // frag_begin, frag_end
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // claim_offset, claim_length, report_lower, report_upper, zero pad
   input  logic [rcg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [1:0]                      rsp_tuser,  // record_kind
   input  logic                            rsp_tlast,
   input  logic                            csr_wr_en,
   input  logic [rcg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              records_due,
   output int                              claims_checked,
   output int                              closes_checked
);
   import rcg_pkg::*;

   logic [OFFSET_BITS-1:0] cfg_lower;
   logic [UPPER_BITS-1:0]  cfg_upper;
   logic                   cfg_auto_lower;
   logic                   cfg_auto_upper;

   logic                   in_report;
   logic                   scope_closed;
   logic [OFFSET_BITS-1:0] held_lower;
   logic [UPPER_BITS-1:0]  end_mark;

   rcg_record_type         expected_records[$];
   rcg_frag_type           frag;
   rcg_record_type         got;
   rcg_record_type         want;

   initial begin
      fail_count     = 0;
      records_due    = 0;
      claims_checked = 0;
      closes_checked = 0;
   end

   function automatic void predict_records(input rcg_frag_type f);
      logic [UPPER_BITS-1:0] end_p1;
      logic [UPPER_BITS-1:0] lo;
      logic [UPPER_BITS-1:0] up;
      logic [UPPER_BITS-1:0] start;
      logic [UPPER_BITS-1:0] len;
      logic [UPPER_BITS-1:0] span;
      logic [UPPER_BITS-1:0] room;
      logic                  bad;
      rcg_record_type        rec;
      end_p1 = {1'b0, f.frag_end} + 1'b1;
      if (!in_report) begin
         in_report    = 1'b1;
         scope_closed = 1'b0;
         end_mark     = '0;
         held_lower   = cfg_auto_lower ? f.frag_begin : cfg_lower;
      end
      if (end_p1 > end_mark) end_mark = end_p1;
      lo  = {1'b0, held_lower};
      up  = cfg_auto_upper ? end_mark : cfg_upper;
      bad = !(lo < up);
      if (!scope_closed && end_p1 > lo) begin
         start = (f.frag_begin > held_lower) ? {1'b0, f.frag_begin} : lo;
         if (!cfg_auto_upper && start >= up) begin
            scope_closed = 1'b1;
         end else if (end_p1 > start && start < up) begin
            len  = end_p1 - start;
            span = up - lo;
            room = up - start;
            if (len > span) len = span;
            if (len > room) len = room;
            if (len != '0) begin
               rec.record_kind    = KIND_CLAIM;
               rec.claim_offset   = start[OFFSET_BITS-1:0] - held_lower;
               rec.claim_length   = len;
               rec.report_lower   = held_lower;
               rec.report_upper   = up;
               rec.last_of_report = 1'b0;
               expected_records.push_back(rec);
            end
         end
      end
      if (f.final_fragment) begin
         rec.record_kind    = bad ? KIND_CLOSE_BAD : KIND_CLOSE_OK;
         rec.claim_offset   = '0;
         rec.claim_length   = '0;
         rec.report_lower   = held_lower;
         rec.report_upper   = up;
         rec.last_of_report = 1'b1;
         expected_records.push_back(rec);
         in_report    = 1'b0;
         scope_closed = 1'b0;
         end_mark     = '0;
      end
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_val, act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_lower      = '0;
         cfg_upper      = '0;
         cfg_auto_lower = 1'b1;
         cfg_auto_upper = 1'b1;
         in_report      = 1'b0;
         scope_closed   = 1'b0;
         held_lower     = '0;
         end_mark       = '0;
         expected_records.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.record_kind    = rcg_kind_type'(rsp_tuser);
            got.claim_offset   = rsp_tdata[0 +: OFFSET_BITS];
            got.claim_length   = rsp_tdata[OFFSET_BITS +: UPPER_BITS];
            got.report_lower   = rsp_tdata[OFFSET_BITS+UPPER_BITS +: OFFSET_BITS];
            got.report_upper   = rsp_tdata[2*OFFSET_BITS+UPPER_BITS +: UPPER_BITS];
            got.last_of_report = rsp_tlast;
            if (expected_records.size() == 0) begin
               $error("record with nothing expected: kind %0d tlast %0b", rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_records.pop_front();
               check_field("record_kind", 64'(want.record_kind), 64'(rsp_tuser));
               check_field("claim_offset", 64'(want.claim_offset), 64'(got.claim_offset));
               check_field("claim_length", 64'(want.claim_length), 64'(got.claim_length));
               check_field("report_lower", 64'(want.report_lower), 64'(got.report_lower));
               check_field("report_upper", 64'(want.report_upper), 64'(got.report_upper));
               check_field("last_of_report", 64'(want.last_of_report),
                           64'(got.last_of_report));
               if (want.record_kind == KIND_CLAIM) claims_checked++;
               else closes_checked++;
            end
         end
         if (csr_wr_en) begin
            case (rcg_reg_type'(csr_index))
               REG_LOWER_LIMIT: cfg_lower = csr_wdata[OFFSET_BITS-1:0];
               REG_UPPER_BOUND: cfg_upper = csr_wdata;
               REG_AUTO_LOWER:  cfg_auto_lower = csr_wdata[0];
               REG_AUTO_UPPER:  cfg_auto_upper = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            frag.frag_begin     = req_tdata[0 +: OFFSET_BITS];
            frag.frag_end       = req_tdata[OFFSET_BITS +: OFFSET_BITS];
            frag.final_fragment = req_tlast;
            predict_records(frag);
         end
      end
      records_due <= expected_records.size();
   end

endmodule

FILE: dv/tb_report_claim_generator_unit.sv
// Testbench top for the report claim generator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_report_claim_generator_unit;
   import rcg_pkg::*;

   localparam int                     ITEMS    = 800;
   localparam int                     DIRECTED = 21;
   localparam int                     TOTAL    = ITEMS + DIRECTED;
   localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
   localparam logic [UPPER_BITS-1:0]  UP_TOP   = {1'b1, {OFFSET_BITS{1'b0}}};

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_wr_en  = 1'b0;
   rcg_reg_type            csr_index  = REG_LOWER_LIMIT;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int fail_count;
   int records_due;
   int claims_checked;
   int closes_checked;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int frags_sent    = 0;
   int reports_sent  = 0;
   int settings_used = 0;

   report_claim_generator_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rcg_record_checker records (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .records_due    (records_due),
      .claims_checked (claims_checked),
      .closes_checked (closes_checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [63:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r & 64'(OFF_MAX);
   endfunction

   task automatic send_frag(input logic [OFFSET_BITS-1:0] fb, fe, input logic fin);
      if (frags_sent < TOTAL / 3) begin
         send_idle_pct = 36;
         recv_idle_pct = 61;
      end else if (frags_sent < 2 * TOTAL / 3) begin
         send_idle_pct = 61;
         recv_idle_pct = 36;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {fe, fb};
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      frags_sent++;
      if (fin) reports_sent++;
   endtask

   // sender holds off until every expected record is back, plus pipeline slack
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (records_due != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [OFFSET_BITS-1:0] lo, input logic [UPPER_BITS-1:0] up,
                                input logic al, au);
      csr_wr_en <= 1'b1;
      csr_index <= REG_LOWER_LIMIT;
      csr_wdata <= {1'($urandom_range(1)), lo};
      @(posedge clock);
      csr_index <= REG_UPPER_BOUND;
      csr_wdata <= up;
      @(posedge clock);
      csr_index <= REG_AUTO_LOWER;
      csr_wdata <= {{OFFSET_BITS{1'b0}}, al};
      @(posedge clock);
      csr_index <= REG_AUTO_UPPER;
      csr_wdata <= {{OFFSET_BITS{1'b0}}, au};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // ascending disjoint fragments with some out-of-order, inverted and wild ones mixed in
   task automatic send_report(input logic [63:0] base, input int nfrag, gap_shift, len_shift);
      logic [63:0] cur;
      logic [63:0] fb;
      logic [63:0] fe;
      int          i;
      cur = base;
      for (i = 0; i < nfrag; i++) begin
         fb = cur + (rand48() >> gap_shift);
         if (fb > OFF_MAX) fb = OFF_MAX;
         fe = fb + (rand48() >> len_shift);
         if (fe > OFF_MAX) fe = OFF_MAX;
         if ($urandom_range(99) < 10) begin
            case ($urandom_range(2))
               0: if (fb >= 8) fe = fb - $urandom_range(1, 8);
               1: begin
                  fb = rand48();
                  fe = rand48();
               end
               default: begin
                  fb = base;
                  fe = base + $urandom_range(40);
                  if (fe > OFF_MAX) fe = OFF_MAX;
               end
            endcase
         end else begin
            cur = fe + 1;
         end
         send_frag(fb[OFFSET_BITS-1:0], fe[OFFSET_BITS-1:0], i == nfrag - 1);
      end
   endtask

   initial begin
      logic [63:0] lo;
      logic [63:0] up;
      logic [63:0] base;
      logic [63:0] dist_back;
      logic        al;
      logic        au;
      int          phase_end;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // both auto modes out of reset
      send_frag('0, '0, 1'b1);
      send_frag(OFF_MAX, OFF_MAX, 1'b1);
      send_frag('0, OFF_MAX, 1'b1);
      send_frag(48'd10, 48'd19, 1'b0);
      send_frag(48'd30, 48'd39, 1'b0);
      send_frag(48'd5, 48'd8, 1'b0);
      send_frag(48'd50, 48'd49, 1'b0);
      send_frag(48'd60, 48'd70, 1'b1);
      wait_idle();

      // explicit bounds: skip below lower, clip both sides, scope end
      apply_setting(48'd100, 49'd200, 1'b0, 1'b0);
      send_frag(48'd50, 48'd99, 1'b0);
      send_frag(48'd90, 48'd120, 1'b0);
      send_frag(48'd150, 48'd250, 1'b0);
      send_frag(48'd200, 48'd210, 1'b0);
      send_frag(48'd210, 48'd220, 1'b0);
      send_frag(48'd300, 48'd300, 1'b1);
      wait_idle();

      apply_setting(48'd500, 49'd400, 1'b0, 1'b0);
      send_frag(48'd450, 48'd600, 1'b1);
      wait_idle();

      apply_setting(OFF_MAX, UP_TOP, 1'b0, 1'b0);
      send_frag(OFF_MAX, OFF_MAX, 1'b1);
      send_frag('0, OFF_MAX, 1'b1);
      wait_idle();

      apply_setting('0, '0, 1'b0, 1'b0);
      send_frag('0, 48'd5, 1'b1);
      wait_idle();

      apply_setting('0, 49'd1000, 1'b1, 1'b0);
      send_frag(48'd900, 48'd1100, 1'b1);
      wait_idle();

      apply_setting(48'd50, '0, 1'b0, 1'b1);
      send_frag('0, 48'd10, 1'b0);
      send_frag(48'd40, 48'd60, 1'b1);
      wait_idle();

      while (frags_sent < TOTAL) begin
         al = 1'($urandom_range(1));
         au = 1'($urandom_range(1));
         case ($urandom_range(5))
            0:       lo = '0;
            1:       lo = OFF_MAX - $urandom_range(300);
            2:       lo = rand48() >> $urandom_range(47);
            default: lo = rand48();
         endcase
         case ($urandom_range(6))
            0:       up = lo + (rand48() >> $urandom_range(30, 47)) + 1;
            1:       up = lo + $urandom_range(1, 600);
            2:       up = UP_TOP;
            3:       up = '0;
            4:       up = (lo > 64) ? lo - $urandom_range(64) : lo;
            5:       up = lo;
            default: up = rand48();
         endcase
         if (up > UP_TOP) up = UP_TOP;
         apply_setting(lo[OFFSET_BITS-1:0], up[UPPER_BITS-1:0], al, au);

         phase_end = frags_sent + 100;
         while (frags_sent < phase_end && frags_sent < TOTAL) begin
            dist_back = rand48() >> $urandom_range(38, 47);
            if (!al)
               base = (lo > dist_back) ? lo - dist_back : '0;
            else if (!au)
               base = (up > dist_back) ? up - dist_back : '0;
            else
               base = rand48() >> $urandom_range(48);
            if ($urandom_range(19) == 0)
               send_report(base, $urandom_range(1, 6), $urandom_range(0, 47),
                           $urandom_range(0, 47));
            else
               send_report(base, $urandom_range(1, 6), $urandom_range(38, 47),
                           $urandom_range(36, 47));
            if ($urandom_range(9) == 0) wait_idle();
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      $display("Covered %0d fragments in %0d reports under %0d register settings.",
               frags_sent, reports_sent, settings_used + 1);
      $display("Checked %0d reception claims and %0d closing records.",
               claims_checked, closes_checked);
      if (fail_count == 0) begin
         $display("** report_claim_generator_unit: PASSED **");
      end else begin
         $display("** report_claim_generator_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d records still due", records_due);
      $display("** report_claim_generator_unit: FAILED **");
      $finish;
   end

endmodule
